FILE: rtl/bac_pkg.sv
// shared types and constants for the burst amplitude classifier
// no dependencies

package bac_pkg;

  localparam int MAX_RECORD_LEN_DEF = 4096;
  localparam int LONG_RUN_MARK_DEF  = 64;

  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int LEN_CFG_W = 13;
  localparam int THR_W    = 16;

  localparam logic [LEN_CFG_W-1:0] MAX_LEN_RST   = 13'd4096;
  localparam logic [LEN_CFG_W-1:0] END_LIMIT_RST = 13'd4096;
  localparam logic [THR_W-1:0]     THR_RST       = 16'd0;

  localparam logic [2:0] REG_MAX_LEN   = 3'd0;
  localparam logic [2:0] REG_END_LIMIT = 3'd1;
  localparam logic [2:0] REG_THR_LEFT  = 3'd2;
  localparam logic [2:0] REG_THR_RIGHT = 3'd3;
  localparam logic [2:0] REG_THR_BOTH  = 3'd4;

  localparam logic [1:0] CLASS_LEFT  = 2'd0;
  localparam logic [1:0] CLASS_RIGHT = 2'd1;

  typedef struct packed {
    logic signed [15:0] mask_value;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [1:0]         class_select;
    logic               last_sample;
  } sample_t;

  typedef struct packed {
    logic one_burst;
    logic heavy;
  } result_t;

  typedef struct packed {
    logic [LEN_CFG_W-1:0] max_len;
    logic [LEN_CFG_W-1:0] end_limit;
    logic [THR_W-1:0]     thr_left;
    logic [THR_W-1:0]     thr_right;
    logic [THR_W-1:0]     thr_both;
  } cfg_t;

endpackage

FILE: rtl/bac_cfg_regs.sv
// configuration register file behind the apb-style port
// depends on bac_pkg

module bac_cfg_regs
  import bac_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_len   <= MAX_LEN_RST;
      cfg.end_limit <= END_LIMIT_RST;
      cfg.thr_left  <= THR_RST;
      cfg.thr_right <= THR_RST;
      cfg.thr_both  <= THR_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_MAX_LEN:   cfg.max_len   <= pwdata[LEN_CFG_W-1:0];
        REG_END_LIMIT: cfg.end_limit <= pwdata[LEN_CFG_W-1:0];
        REG_THR_LEFT:  cfg.thr_left  <= pwdata[THR_W-1:0];
        REG_THR_RIGHT: cfg.thr_right <= pwdata[THR_W-1:0];
        REG_THR_BOTH:  cfg.thr_both  <= pwdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAX_LEN:   prdata = DATA_W'(cfg.max_len);
      REG_END_LIMIT: prdata = DATA_W'(cfg.end_limit);
      REG_THR_LEFT:  prdata = DATA_W'(cfg.thr_left);
      REG_THR_RIGHT: prdata = DATA_W'(cfg.thr_right);
      REG_THR_BOTH:  prdata = DATA_W'(cfg.thr_both);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: rtl/bac_tracker.sv
// record state: run and block tracking, span capture and end-of-record decision
// depends on bac_pkg

module bac_tracker
  import bac_pkg::*;
#(
  parameter int MAX_RECORD_LEN = MAX_RECORD_LEN_DEF,
  parameter int LONG_RUN_MARK  = LONG_RUN_MARK_DEF
)(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  sample_t item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int POS_W = $clog2(MAX_RECORD_LEN);
  localparam int RUN_W = $clog2(MAX_RECORD_LEN + 1);
  localparam int LEN_W = (POS_W + 1 > LEN_CFG_W) ? POS_W + 1 : LEN_CFG_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_RECORD_LEN - 1);
  localparam logic [RUN_W-1:0] RUN_MAX  = RUN_W'(MAX_RECORD_LEN);

  logic [POS_W-1:0]   position, position_next;
  logic [RUN_W-1:0]   run_length, run_length_next;
  logic [1:0]         block_count, block_count_next;
  logic signed [15:0] left_min, left_max, right_min, right_max;
  logic signed [15:0] left_min_next, left_max_next, right_min_next, right_max_next;
  logic [POS_W-1:0]   last_block_start, last_block_start_next;
  logic [POS_W-1:0]   last_block_end, last_block_end_next;
  logic [POS_W-1:0]   prev_block_end, prev_block_end_next;
  logic [16:0]        last_left_span, last_left_span_next;
  logic [16:0]        last_right_span, last_right_span_next;

  logic             active;
  logic [RUN_W-1:0] pos_ext;
  logic [LEN_W-1:0] block_len;
  logic [16:0]      span_max;
  logic [THR_W-1:0] thr;
  logic             burst;

  assign active  = item.mask_value > 16'sd0;
  assign pos_ext = RUN_W'(position);

  always_comb begin
    position_next         = (position < POS_LAST) ? position + 1'b1 : position;
    run_length_next       = run_length;
    block_count_next      = block_count;
    left_min_next         = left_min;
    left_max_next         = left_max;
    right_min_next        = right_min;
    right_max_next        = right_max;
    last_block_start_next = last_block_start;
    last_block_end_next   = last_block_end;
    prev_block_end_next   = prev_block_end;
    last_left_span_next   = last_left_span;
    last_right_span_next  = last_right_span;
    if (active) begin
      if (run_length == '0) begin
        left_min_next  = item.left_sample;
        left_max_next  = item.left_sample;
        right_min_next = item.right_sample;
        right_max_next = item.right_sample;
      end else begin
        if (item.left_sample < left_min)   left_min_next  = item.left_sample;
        if (item.left_sample > left_max)   left_max_next  = item.left_sample;
        if (item.right_sample < right_min) right_min_next = item.right_sample;
        if (item.right_sample > right_max) right_max_next = item.right_sample;
      end
      if (run_length < RUN_MAX) run_length_next = run_length + 1'b1;
    end else if (run_length != '0) begin
      prev_block_end_next   = last_block_end;
      last_block_start_next = (pos_ext >= run_length) ?
                              POS_W'(pos_ext - run_length) : '0;
      last_block_end_next   = (position != '0) ? position - 1'b1 : '0;
      last_left_span_next   = 17'({left_max[15], left_max} - {left_min[15], left_min});
      last_right_span_next  = 17'({right_max[15], right_max} - {right_min[15], right_min});
      if (block_count < 2'd2) block_count_next = block_count + 1'b1;
      run_length_next = '0;
    end
  end

  // decision on the state as it stands after this item
  assign block_len = LEN_W'(last_block_end_next) - LEN_W'(last_block_start_next) + 1'b1;
  assign span_max  = (last_left_span_next > last_right_span_next) ?
                     last_left_span_next : last_right_span_next;

  always_comb begin
    case (item.class_select)
      CLASS_LEFT:  thr = cfg.thr_left;
      CLASS_RIGHT: thr = cfg.thr_right;
      default:     thr = cfg.thr_both;
    endcase
  end

  always_comb begin
    if (block_count_next == 2'd0 && 32'(run_length_next) < 32'(LONG_RUN_MARK))
      burst = 1'b0;
    else if (32'(run_length_next) == 32'(LONG_RUN_MARK))
      burst = 1'b0;
    else if (block_count_next == 2'd1 && block_len > LEN_W'(cfg.max_len))
      burst = 1'b0;
    else if (block_count_next == 2'd2 &&
             LEN_W'(prev_block_end_next) > LEN_W'(cfg.end_limit))
      burst = 1'b0;
    else if (block_count_next == 2'd0)
      burst = 1'b0;
    else
      burst = 1'b1;
  end

  assign result.one_burst = burst;
  assign result.heavy     = burst && (span_max > 17'(thr));

  always_ff @(posedge clk) begin
    if (rst) begin
      position         <= '0;
      run_length       <= '0;
      block_count      <= '0;
      last_block_start <= '0;
      last_block_end   <= '0;
      prev_block_end   <= '0;
      last_left_span   <= '0;
      last_right_span  <= '0;
    end else if (step) begin
      if (item.last_sample) begin
        position         <= '0;
        run_length       <= '0;
        block_count      <= '0;
        last_block_start <= '0;
        last_block_end   <= '0;
        prev_block_end   <= '0;
        last_left_span   <= '0;
        last_right_span  <= '0;
      end else begin
        position         <= position_next;
        run_length       <= run_length_next;
        block_count      <= block_count_next;
        last_block_start <= last_block_start_next;
        last_block_end   <= last_block_end_next;
        prev_block_end   <= prev_block_end_next;
        last_left_span   <= last_left_span_next;
        last_right_span  <= last_right_span_next;
      end
    end
  end

  // min/max are loaded by the first active sample of a run before use
  always_ff @(posedge clk) begin
    if (step) begin
      left_min  <= left_min_next;
      left_max  <= left_max_next;
      right_min <= right_min_next;
      right_max <= right_max_next;
    end
  end

endmodule

FILE: rtl/burst_amplitude_classifier.sv
// burst amplitude classifier: one sample item per cycle, one result per record.
// a last item is held in the item register, and its decision is then captured in the
// result register. the input takes one item every cycle; it
// stalls only when a last item meets a result not yet taken.
// reset: synchronous, clears record state, handshakes and configuration.
// depends on bac_pkg, bac_cfg_regs, bac_tracker

module burst_amplitude_classifier
  import bac_pkg::*;
#(
  parameter int MAX_RECORD_LEN = MAX_RECORD_LEN_DEF,
  parameter int LONG_RUN_MARK  = LONG_RUN_MARK_DEF
)(
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  sample_t           sample,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  sample_t item;
  logic    item_valid;
  logic    advance;
  result_t decision;

  assign advance      = item_valid && (!item.last_sample || !result_valid || result_ready);
  assign sample_ready = !item_valid || advance;

  bac_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bac_tracker #(
    .MAX_RECORD_LEN (MAX_RECORD_LEN),
    .LONG_RUN_MARK  (LONG_RUN_MARK)
  ) u_tracker (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (decision)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (sample_ready) begin
      item_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      item <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (advance && item.last_sample) || (result_valid && !result_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last_sample) begin
      result <= decision;
    end
  end

endmodule

FILE: rtl/bac_checker.sv
// port-level checks for the burst amplitude classifier, bound to the top level
// depends on bac_pkg

module bac_checker
  import bac_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_ready,
  input sample_t sample,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_heavy_needs_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.heavy && !result.one_burst))
    else $error("heavy without a burst");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> result_valid && !result_ready)
    else $error("input stalled without a held result");

endmodule

bind burst_amplitude_classifier bac_checker u_checker (.*);

FILE: verif/bac_verdict_check.sv
`timescale 1ns / 1ps
// scoreboard for burst_amplitude_classifier: tracks config writes, predicts the
// per-record verdict from accepted sample items, checks results and register reads
// depends on bac_pkg

module bac_verdict_check
  import bac_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  input  logic              sample_ready,
  input  sample_t           sample,
  input  logic              result_valid,
  input  logic              result_ready,
  input  result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);

  localparam int REC_MAX  = MAX_RECORD_LEN_DEF;
  localparam int RUN_MARK = LONG_RUN_MARK_DEF;

  logic [LEN_CFG_W-1:0] max_len;
  logic [LEN_CFG_W-1:0] end_limit;
  logic [THR_W-1:0]     thr_left;
  logic [THR_W-1:0]     thr_right;
  logic [THR_W-1:0]     thr_both;

  int pos;
  int run_len;
  int blocks;
  int l_lo, l_hi, r_lo, r_hi;
  int blk_start, blk_end, prev_end;
  int l_span, r_span;

  result_t verdict_q[$];
  result_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_record();
    pos       = 0;
    run_len   = 0;
    blocks    = 0;
    l_lo      = 0;
    l_hi      = 0;
    r_lo      = 0;
    r_hi      = 0;
    blk_start = 0;
    blk_end   = 0;
    prev_end  = 0;
    l_span    = 0;
    r_span    = 0;
  endtask

  function automatic logic [DATA_W-1:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_MAX_LEN:   return DATA_W'(max_len);
      REG_END_LIMIT: return DATA_W'(end_limit);
      REG_THR_LEFT:  return DATA_W'(thr_left);
      REG_THR_RIGHT: return DATA_W'(thr_right);
      REG_THR_BOTH:  return DATA_W'(thr_both);
      default:       return '0;
    endcase
  endfunction

  task automatic track_sample(input sample_t s);
    int      m, l, r, peak, lim;
    bit      burst;
    result_t v;
    m = $signed(s.mask_value);
    l = $signed(s.left_sample);
    r = $signed(s.right_sample);
    if (m > 0) begin
      if (run_len == 0) begin
        l_lo = l;
        l_hi = l;
        r_lo = r;
        r_hi = r;
      end else begin
        if (l < l_lo) l_lo = l;
        if (l > l_hi) l_hi = l;
        if (r < r_lo) r_lo = r;
        if (r > r_hi) r_hi = r;
      end
      if (run_len < REC_MAX) run_len++;
    end else if (run_len > 0) begin
      prev_end  = blk_end;
      blk_start = (pos >= run_len) ? pos - run_len : 0;
      blk_end   = (pos >= 1) ? pos - 1 : 0;
      l_span    = l_hi - l_lo;
      r_span    = r_hi - r_lo;
      if (blocks < 2) blocks++;
      run_len = 0;
    end
    if (pos < REC_MAX - 1) pos++;
    if (s.last_sample) begin
      if (blocks == 0 && run_len < RUN_MARK) burst = 1'b0;
      else if (run_len == RUN_MARK) burst = 1'b0;
      else if (blocks == 1 && blk_end - blk_start + 1 > int'(max_len)) burst = 1'b0;
      else if (blocks >= 2 && prev_end > int'(end_limit)) burst = 1'b0;
      else if (blocks == 0) burst = 1'b0;
      else burst = 1'b1;
      peak = (l_span > r_span) ? l_span : r_span;
      if (s.class_select == CLASS_LEFT) lim = int'(thr_left);
      else if (s.class_select == CLASS_RIGHT) lim = int'(thr_right);
      else lim = int'(thr_both);
      v.one_burst = burst;
      v.heavy     = burst && (peak > lim);
      verdict_q.push_back(v);
      clear_record();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      max_len   = MAX_LEN_RST;
      end_limit = END_LIMIT_RST;
      thr_left  = THR_RST;
      thr_right = THR_RST;
      thr_both  = THR_RST;
      clear_record();
      verdict_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[ADDR_W-1:2])
            REG_MAX_LEN:   max_len   = pwdata[LEN_CFG_W-1:0];
            REG_END_LIMIT: end_limit = pwdata[LEN_CFG_W-1:0];
            REG_THR_LEFT:  thr_left  = pwdata[THR_W-1:0];
            REG_THR_RIGHT: thr_right = pwdata[THR_W-1:0];
            REG_THR_BOTH:  thr_both  = pwdata[THR_W-1:0];
            default: ;
          endcase
        end else if (prdata !== reg_value(paddr[ADDR_W-1:2])) begin
          report($sformatf("register read at 0x%0h: got 0x%0h, want 0x%0h",
                           paddr, prdata, reg_value(paddr[ADDR_W-1:2])));
        end
      end
      if (sample_valid && sample_ready) track_sample(sample);
      if (result_valid && result_ready) begin
        if (verdict_q.size() == 0) begin
          report($sformatf("unexpected result one_burst=%b heavy=%b",
                           result.one_burst, result.heavy));
        end else begin
          want = verdict_q.pop_front();
          if (result.one_burst !== want.one_burst)
            report($sformatf("one_burst: got %b, want %b", result.one_burst, want.one_burst));
          if (result.heavy !== want.heavy)
            report($sformatf("heavy: got %b, want %b", result.heavy, want.heavy));
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// top-level testbench for burst_amplitude_classifier: directed and random records,
// register writes and reads between phases, random stalls on both item channels
// depends on bac_pkg, burst_amplitude_classifier, bac_verdict_check

module tb_top;
  import bac_pkg::*;

  localparam int CYCLE = 12;
  localparam logic [1:0] CLASS_BOTH  = 2'd2;
  localparam logic [1:0] CLASS_SPARE = 2'd3;

  logic              clk;
  logic              rst;
  logic              sample_valid;
  logic              sample_ready;
  sample_t           sample;
  logic              result_valid;
  logic              result_ready;
  result_t           result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int sent;
  bit quiet = 1'b0;

  burst_amplitude_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  bac_verdict_check verdict_check (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CYCLE / 2) clk = ~clk;
  end

  initial begin
    #(CYCLE * 1_500_000);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    result_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      result_ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  end

  function automatic sample_t item(input int mask, input int l, input int r,
                                   input logic [1:0] cls, input bit last);
    sample_t s;
    s.mask_value   = 16'(mask);
    s.left_sample  = 16'(l);
    s.right_sample = 16'(r);
    s.class_select = cls;
    s.last_sample  = last;
    return s;
  endfunction

  function automatic int level(input int amp);
    if (amp >= 32768) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  function automatic int idle_mask();
    if ($urandom_range(0, 1) == 0) return 0;
    return -int'($urandom_range(1, 32768));
  endfunction

  function automatic int active_mask();
    case ($urandom_range(0, 7))
      0:       return 1;
      1:       return 32767;
      default: return int'($urandom_range(1, 32767));
    endcase
  endfunction

  task automatic send_item(input sample_t s);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (!sample_ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [2:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input int max_len, input int end_limit,
                            input int tl, input int tr, input int tb);
    apb_xfer(1'b1, REG_MAX_LEN, DATA_W'(max_len));
    apb_xfer(1'b1, REG_END_LIMIT, DATA_W'(end_limit));
    apb_xfer(1'b1, REG_THR_LEFT, DATA_W'(tl));
    apb_xfer(1'b1, REG_THR_RIGHT, DATA_W'(tr));
    apb_xfer(1'b1, REG_THR_BOTH, DATA_W'(tb));
    apb_xfer(1'b0, REG_MAX_LEN, '0);
    apb_xfer(1'b0, REG_END_LIMIT, '0);
    apb_xfer(1'b0, REG_THR_LEFT, '0);
    apb_xfer(1'b0, REG_THR_RIGHT, '0);
    apb_xfer(1'b0, REG_THR_BOTH, '0);
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_record();
    int shape, nblk, amp, open_len, n;
    shape    = $urandom_range(0, 9);
    amp      = ($urandom_range(0, 3) == 0) ? 32768 : $urandom_range(0, 2500);
    open_len = 0;
    if (shape == 0) begin
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++)
        send_item(item(level(32768), level(32768), level(32768),
                       2'($urandom_range(0, 3)), i == n - 1));
    end else begin
      nblk = $urandom_range(0, 3);
      for (int b = 0; b < nblk; b++) begin
        n = $urandom_range(b == 0 ? 0 : 1, 6);
        for (int i = 0; i < n; i++)
          send_item(item(idle_mask(), level(amp), level(amp), 2'($urandom_range(0, 3)), 0));
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
          send_item(item(active_mask(), level(amp), level(amp), 2'($urandom_range(0, 3)), 0));
      end
      if (shape == 9) begin
        case ($urandom_range(0, 3))
          0:       open_len = 63;
          1:       open_len = 64;
          2:       open_len = 65;
          default: open_len = $urandom_range(66, 80);
        endcase
      end else if (shape >= 7) begin
        open_len = $urandom_range(1, 10);
      end
      if (nblk > 0 || open_len == 0) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          send_item(item(idle_mask(), level(amp), level(amp), 2'($urandom_range(0, 3)),
                         open_len == 0 && i == n - 1));
      end
      for (int i = 0; i < open_len; i++)
        send_item(item(active_mask(), level(amp), level(amp), 2'($urandom_range(0, 3)),
                       i == open_len - 1));
    end
  endtask

  initial begin
    int stop_at;
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sent         = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset config: limits 4096, thresholds zero
    send_item(item(0, 0, 0, CLASS_LEFT, 1));
    send_item(item(32767, -32768, 32767, CLASS_LEFT, 0));
    send_item(item(1, 32767, -32768, CLASS_RIGHT, 0));
    send_item(item(-32768, 0, 0, CLASS_SPARE, 1));
    send_item(item(5, 100, -7, CLASS_BOTH, 0));
    send_item(item(0, 0, 0, CLASS_LEFT, 1));
    send_item(item(9, -300, 40, CLASS_LEFT, 0));
    send_item(item(-1, 0, 0, CLASS_LEFT, 0));
    send_item(item(9, 12, -12, CLASS_LEFT, 0));
    send_item(item(0, 0, 0, CLASS_RIGHT, 1));
    send_item(item(3, 1, 2, CLASS_LEFT, 0));
    send_item(item(0, 0, 0, CLASS_LEFT, 0));
    send_item(item(3, -5, 5, CLASS_BOTH, 1));
    send_item(item(7, 0, 0, CLASS_LEFT, 1));

    for (int ph = 1; ph <= 8; ph++) begin
      settle();
      case (ph)
        1: set_config(0, 0, 65535, 65535, 65535);
        2: set_config(4096, 4096, 0, 0, 0);
        3: set_config(8191, 8191, 0, 65535, 1);
        default: set_config(
          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 40),
          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 60),
          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 5000),
          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 5000),
          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 5000));
      endcase
      if (ph == 8) quiet = 1'b1;
      if (ph == 2) begin
        // record longer than the position counter
        for (int i = 0; i < 30; i++)
          send_item(item(idle_mask(), level(32768), level(32768), 2'($urandom_range(0, 3)), 0));
        for (int i = 0; i < 4100; i++)
          send_item(item(active_mask(), level(2000), level(2000), 2'($urandom_range(0, 3)), 0));
        send_item(item(idle_mask(), 0, 0, 2'($urandom_range(0, 3)), 1));
      end
      stop_at = sent + 65;
      while (sent < stop_at) send_record();
    end

    sample_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bac_pkg.sv
rtl/bac_cfg_regs.sv
rtl/bac_tracker.sv
rtl/burst_amplitude_classifier.sv
rtl/bac_checker.sv
verif/bac_verdict_check.sv
verif/tb_top.sv
